// ===== rtl/ctse_pkg.sv =====
// Shared types and constants for the calendar time-set editor.
// No dependencies; imported by ctse_next and clock_time_set_editor.
package ctse_pkg;

	localparam int unsigned PERIOD_W = 16;

	// request codes
	localparam logic [2:0] REQ_LOAD   = 3'd0;
	localparam logic [2:0] REQ_MODE   = 3'd1;
	localparam logic [2:0] REQ_SELECT = 3'd2;
	localparam logic [2:0] REQ_INC    = 3'd3;
	localparam logic [2:0] REQ_DEC    = 3'd4;
	localparam logic [2:0] REQ_TICK   = 3'd5;

	// field select codes
	localparam logic [2:0] FLD_YEAR    = 3'd0;
	localparam logic [2:0] FLD_MONTH   = 3'd1;
	localparam logic [2:0] FLD_DAY     = 3'd2;
	localparam logic [2:0] FLD_HOUR    = 3'd3;
	localparam logic [2:0] FLD_MINUTE  = 3'd4;
	localparam logic [2:0] FLD_SECOND  = 3'd5;
	localparam logic [2:0] FLD_WEEKDAY = 3'd6;

	localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = PERIOD_W'(500);

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
	} ctse_time_t;

	typedef struct packed {
		logic                mode;
		logic [2:0]          fsel;
		logic                blink;
		logic [PERIOD_W-1:0] tick;
		ctse_time_t          tm;
	} ctse_state_t;

	localparam ctse_state_t STATE_RST = '{
		mode:  1'b0,
		fsel:  FLD_YEAR,
		blink: 1'b0,
		tick:  '0,
		tm:    '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
		         minute: 6'd0, second: 6'd0, weekday: 3'd1}
	};

endpackage

// ===== rtl/clock_time_set_editor.sv =====
// Top level of the calendar time-set editor: input stage, state, result stage.
// Depends on ctse_pkg and ctse_next.
//
//  channel | handshake             | word
//  --------+-----------------------+---------------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_data: blink half period in ticks
//  in      | in_valid / in_ready   | req_type, in_year .. in_weekday
//  out     | out_valid / out_ready | set_mode, selected_field, blank_selected,
//          |                       | out_year .. out_weekday, write_time
//
// One word per cycle sustained while out_ready stays high. A word waits in the input
// register; the state update and the result are computed in one pass when it moves
// into the result register, so a word's result shows on the ports only after that
// move and is held there until out_ready takes it.
// A stalled output holds the result register; the input register still takes
// one more word. cfg_ready is always high. Reset loads 0-1-1 0:00:00, weekday 1,
// display mode, period 500; no clearing pass is needed.
module clock_time_set_editor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ctse_pkg::PERIOD_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    req_type,
	input  logic [6:0]                    in_year,
	input  logic [3:0]                    in_month,
	input  logic [4:0]                    in_day,
	input  logic [4:0]                    in_hour,
	input  logic [5:0]                    in_minute,
	input  logic [5:0]                    in_second,
	input  logic [2:0]                    in_weekday,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          set_mode,
	output logic [2:0]                    selected_field,
	output logic                          blank_selected,
	output logic [6:0]                    out_year,
	output logic [3:0]                    out_month,
	output logic [4:0]                    out_day,
	output logic [4:0]                    out_hour,
	output logic [5:0]                    out_minute,
	output logic [5:0]                    out_second,
	output logic [2:0]                    out_weekday,
	output logic                          write_time
);
	import ctse_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	ctse_state_t         state_q;
	ctse_state_t         state_nxt;
	logic                wr_nxt;

	// input stage
	logic       valid_s1;
	logic [2:0] req_s1;
	ctse_time_t ld_s1;

	// result stage
	logic        valid_s2;
	ctse_state_t res_s2;
	logic        wr_s2;

	logic adv;

	// advance the input word when the result register is free or being drained
	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= BLINK_PERIOD_RST;
		end else if (cfg_valid) begin
			period_q <= cfg_data;
		end
	end

	// hold the accepted word until it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= req_type;
			ld_s1  <= '{year: in_year, month: in_month, day: in_day, hour: in_hour,
			           minute: in_minute, second: in_second, weekday: in_weekday};
		end
	end

	ctse_next u_next (
		.cur       (state_q),
		.req       (req_s1),
		.ld        (ld_s1),
		.period    (period_q),
		.nxt       (state_nxt),
		.wr_strobe (wr_nxt)
	);

	// commit the state only when the word leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= state_nxt;
			wr_s2  <= wr_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign set_mode       = res_s2.mode;
	assign selected_field = res_s2.fsel;
	assign blank_selected = res_s2.mode & res_s2.blink;
	assign out_year       = res_s2.tm.year;
	assign out_month      = res_s2.tm.month;
	assign out_day        = res_s2.tm.day;
	assign out_hour       = res_s2.tm.hour;
	assign out_minute     = res_s2.tm.minute;
	assign out_second     = res_s2.tm.second;
	assign out_weekday    = res_s2.tm.weekday;
	assign write_time     = wr_s2;

	a_wr_leaves_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_time |-> !set_mode)
		else $error("write strobe while still in set mode");

	a_fsel_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fsel <= FLD_WEEKDAY)
		else $error("field select out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1))
		else $error("input stage dropped a waiting word");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("state changed without a word advancing");

endmodule

// ===== rtl/ctse_next.sv =====
// Next-state logic of the time-set editor: load, mode, select, edit, tick.
// Depends on ctse_pkg (state types, request and field codes).
module ctse_next (
	input  ctse_pkg::ctse_state_t         cur,
	input  logic [2:0]                    req,
	input  ctse_pkg::ctse_time_t          ld,
	input  logic [ctse_pkg::PERIOD_W-1:0] period,
	output ctse_pkg::ctse_state_t         nxt,
	output logic                          wr_strobe
);
	import ctse_pkg::*;

	function automatic logic [4:0] month_len(logic [3:0] m, logic [6:0] y);
		logic [4:0] len;
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

	// wrap up or down within lo..hi
	function automatic logic [6:0] wrap_step(logic [6:0] v, logic [6:0] lo,
	                                         logic [6:0] hi, logic up);
		logic [6:0] r;
		if (up) begin
			r = (v >= hi) ? lo : v + 7'd1;
		end else begin
			r = (v <= lo || v > hi) ? hi : v - 7'd1;
		end
		return r;
	endfunction

	logic                up;
	logic [4:0]          ml_cur;
	logic [4:0]          ml_new;
	ctse_time_t          ed;
	logic [PERIOD_W:0]   tick_sum;

	assign up       = (req == REQ_INC);
	assign ml_cur   = month_len(cur.tm.month, cur.tm.year);
	assign tick_sum = {1'b0, cur.tick} + {{PERIOD_W{1'b0}}, 1'b1};

	always_comb begin
		ed = cur.tm;
		case (cur.fsel)
			FLD_YEAR: begin
				ed.year = wrap_step(cur.tm.year, 7'd0, 7'd99, up);
			end
			FLD_MONTH: begin
				ed.month = 4'(wrap_step({3'b0, cur.tm.month}, 7'd1, 7'd12, up));
			end
			FLD_DAY: begin
				ed.day = 5'(wrap_step({2'b0, cur.tm.day}, 7'd1, {2'b0, ml_cur}, up));
			end
			FLD_HOUR: begin
				ed.hour = 5'(wrap_step({2'b0, cur.tm.hour}, 7'd0, 7'd23, up));
			end
			FLD_MINUTE: begin
				ed.minute = 6'(wrap_step({1'b0, cur.tm.minute}, 7'd0, 7'd59, up));
			end
			FLD_SECOND: begin
				ed.second = 6'(wrap_step({1'b0, cur.tm.second}, 7'd0, 7'd59, up));
			end
			FLD_WEEKDAY: begin
				ed.weekday = 3'(wrap_step({4'b0, cur.tm.weekday}, 7'd1, 7'd7, up));
			end
			default: begin
			end
		endcase
		ml_new = month_len(ed.month, ed.year);
		// fold a day past the month end back to the first
		if (ed.day > ml_new) begin
			ed.day = 5'd1;
		end
	end

	always_comb begin
		nxt       = cur;
		wr_strobe = 1'b0;
		case (req)
			REQ_LOAD: begin
				if (!cur.mode) nxt.tm = ld;
			end
			REQ_MODE: begin
				nxt.mode  = ~cur.mode;
				wr_strobe = cur.mode;
			end
			REQ_SELECT: begin
				if (cur.mode) nxt.fsel = (cur.fsel >= FLD_WEEKDAY) ? FLD_YEAR : cur.fsel + 3'd1;
			end
			REQ_INC, REQ_DEC: begin
				if (cur.mode) nxt.tm = ed;
			end
			REQ_TICK: begin
				if (tick_sum >= {1'b0, period}) begin
					nxt.tick  = '0;
					nxt.blink = ~cur.blink;
				end else begin
					nxt.tick = tick_sum[PERIOD_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
